FILE: rtl/core/rhu_pkg.sv
// ----------------------------------------------------------------------------
// rhu_pkg
// shared types, widths and constants of the relative heading unit
// ----------------------------------------------------------------------------
package rhu_pkg;

   // normalized magnitude width: leading one lands on bit NORM_W-1
   localparam int NORM_W       = 41;
   // cordic datapath widths
   localparam int XW           = 44;
   localparam int ZW           = 30;
   localparam int CORDIC_STEPS = 24;
   // pi in q16 milliradians
   localparam logic signed [31:0] PI_Q16 = 32'sd205887416;

   // per item control that travels beside the datapath
   typedef struct packed {
      logic        valid;
      logic        zero;
      logic        dx_neg;
      logic        dy_neg;
      logic [13:0] orient;
   } side_type;

   typedef struct packed {
      logic [NORM_W-1:0] x;
      logic [NORM_W-1:0] y;
   } pair_type;

   // atan(2^-i) in q16 milliradians
   function automatic logic signed [ZW-1:0] atan_q16(input int i);
      logic signed [ZW-1:0] a;
      unique case (i)
         0:  a = 30'sd51471854;
         1:  a = 30'sd30385610;
         2:  a = 30'sd16054922;
         3:  a = 30'sd8149729;
         4:  a = 30'sd4090679;
         5:  a = 30'sd2047334;
         6:  a = 30'sd1023917;
         7:  a = 30'sd511990;
         8:  a = 30'sd255999;
         9:  a = 30'sd128000;
         10: a = 30'sd64000;
         11: a = 30'sd32000;
         12: a = 30'sd16000;
         13: a = 30'sd8000;
         14: a = 30'sd4000;
         15: a = 30'sd2000;
         16: a = 30'sd1000;
         17: a = 30'sd500;
         18: a = 30'sd250;
         19: a = 30'sd125;
         20: a = 30'sd62;
         21: a = 30'sd31;
         22: a = 30'sd16;
         23: a = 30'sd8;
         default: a = '0;
      endcase
      return a;
   endfunction

   // one step of the binary normalize search: shift by k when the top k bits are clear
   function automatic pair_type norm_step(input pair_type p, input int k);
      pair_type r;
      logic [NORM_W-1:0] both;
      both = p.x | p.y;
      r = p;
      if ((both >> (NORM_W - k)) == '0) begin
         r.x = p.x << k;
         r.y = p.y << k;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/rhu_norm.sv
// ----------------------------------------------------------------------------
// rhu_norm
// three stage normalizer: doubles both magnitudes until the leading one hits the top bit
// ----------------------------------------------------------------------------
module rhu_norm #(
   parameter int MAG_W = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [MAG_W-1:0]    mag_x,
   input  logic [MAG_W-1:0]    mag_y,
   input  rhu_pkg::side_type   side_src,
   output rhu_pkg::pair_type   norm_pair,
   output rhu_pkg::side_type   norm_side
);

   rhu_pkg::pair_type p0, p1_in, p2_in, p3_in;
   rhu_pkg::pair_type p1_ff, p2_ff, p3_ff;
   rhu_pkg::side_type s1_ff, s2_ff, s3_ff;

   // search by 32/16, then 8/4, then 2/1
   always_comb begin
      p0.x  = {{(rhu_pkg::NORM_W-MAG_W){1'b0}}, mag_x};
      p0.y  = {{(rhu_pkg::NORM_W-MAG_W){1'b0}}, mag_y};
      p1_in = rhu_pkg::norm_step(rhu_pkg::norm_step(p0, 32), 16);
      p2_in = rhu_pkg::norm_step(rhu_pkg::norm_step(p1_ff, 8), 4);
      p3_in = rhu_pkg::norm_step(rhu_pkg::norm_step(p2_ff, 2), 1);
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         s1_ff <= side_src;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end
   end

   assign norm_pair = p3_ff;
   assign norm_side = s3_ff;

endmodule

FILE: rtl/core/rhu_cordic.sv
// ----------------------------------------------------------------------------
// rhu_cordic
// vectoring cordic, one register stage per iteration, first quadrant angle in q16 mrad
// ----------------------------------------------------------------------------
module rhu_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  rhu_pkg::pair_type                   norm_pair,
   input  rhu_pkg::side_type                   norm_side,
   output logic signed [rhu_pkg::ZW-1:0]       z_angle,
   output rhu_pkg::side_type                   z_side
);

   localparam int N = rhu_pkg::CORDIC_STEPS;

   logic signed [rhu_pkg::XW-1:0] x_ff [N];
   logic signed [rhu_pkg::XW-1:0] y_ff [N];
   logic signed [rhu_pkg::ZW-1:0] z_ff [N];
   rhu_pkg::side_type             s_ff [N];
   logic signed [rhu_pkg::XW-1:0] x_in [N];
   logic signed [rhu_pkg::XW-1:0] y_in [N];
   logic signed [rhu_pkg::ZW-1:0] z_in [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [rhu_pkg::XW-1:0] x_src, y_src;
      logic signed [rhu_pkg::ZW-1:0] z_src;
      rhu_pkg::side_type             s_src;

      if (i == 0) begin : g_first
         assign x_src = {{(rhu_pkg::XW-rhu_pkg::NORM_W){1'b0}}, norm_pair.x};
         assign y_src = {{(rhu_pkg::XW-rhu_pkg::NORM_W){1'b0}}, norm_pair.y};
         assign z_src = '0;
         assign s_src = norm_side;
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
         assign s_src = s_ff[i-1];
      end

      // rotate toward the x axis
      always_comb begin
         if (y_src >= 0) begin
            x_in[i] = x_src + (y_src >>> i);
            y_in[i] = y_src - (x_src >>> i);
            z_in[i] = z_src + rhu_pkg::atan_q16(i);
         end else begin
            x_in[i] = x_src - (y_src >>> i);
            y_in[i] = y_src + (x_src >>> i);
            z_in[i] = z_src - rhu_pkg::atan_q16(i);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            s_ff[i] <= s_src;
         end
         if (reset) begin
            s_ff[i].valid <= 1'b0;
         end
      end
   end

   assign z_angle = z_ff[N-1];
   assign z_side  = s_ff[N-1];

endmodule

FILE: rtl/core/rhu_post.sv
// ----------------------------------------------------------------------------
// rhu_post
// quadrant fold, rounding and wrap, then shortest path unwrap and relative heading
// ----------------------------------------------------------------------------
module rhu_post #(
   parameter int TWO_PI = 6283
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic signed [rhu_pkg::ZW-1:0] z_angle,
   input  rhu_pkg::side_type             z_side,
   output logic                          out_valid,
   output logic [12:0]                   abs_heading,
   output logic                          heading_valid,
   output logic [14:0]                   relative_heading
);

   localparam logic [31:0]        BIAS = 32'(TWO_PI * 65536 + 32768);
   localparam logic [15:0]        T16  = 16'(TWO_PI);
   localparam logic signed [16:0] T17  = 17'(TWO_PI);

   logic [31:0]       sh_in, sh_ff;
   rhu_pkg::side_type s1_ff, s2_ff;
   logic [12:0]       head_in, head_ff;
   logic [15:0]       q;
   logic signed [31:0] a, s;
   logic signed [16:0] e, r, d;
   logic [14:0]       rel_in;

   // signed angle over all four quadrants, biased by two pi and half a unit
   always_comb begin
      a = 32'(z_angle);
      priority if (!z_side.dx_neg && !z_side.dy_neg) s = a;
      else if (!z_side.dx_neg)                       s = -a;
      else if (!z_side.dy_neg)                       s = rhu_pkg::PI_Q16 - a;
      else                                           s = a - rhu_pkg::PI_Q16;
      sh_in = s + BIAS;
   end

   // round and wrap into 0..two pi - 1
   always_comb begin
      q = sh_ff[31:16];
      if (s1_ff.zero)   head_in = '0;
      else if (q >= T16) head_in = 13'(q - T16);
      else              head_in = q[12:0];
   end

   // unwrap toward the orientation, then subtract it
   always_comb begin
      e = {4'b0, head_ff};
      r = {{3{s2_ff.orient[13]}}, s2_ff.orient};
      if (r == T17)       e = e + T17;
      else if (r == -T17) e = e - T17;
      d = e - r;
      if (d < 0) begin
         if ((e + T17 - r) < (r - e)) e = e + T17;
      end else if (d > 0) begin
         if ((e - r) > (r + T17 - e)) e = e - T17;
      end
      rel_in = 15'(e - r);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sh_ff            <= sh_in;
         s1_ff            <= z_side;
         head_ff          <= head_in;
         s2_ff            <= s1_ff;
         abs_heading      <= head_ff;
         heading_valid    <= !s2_ff.zero;
         relative_heading <= rel_in;
         out_valid        <= s2_ff.valid;
      end
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         out_valid   <= 1'b0;
      end
   end

endmodule

FILE: rtl/core/relative_heading_unit.sv
// ----------------------------------------------------------------------------
// relative_heading_unit
// heading from a reference point to a target, absolute and relative to orientation
// ----------------------------------------------------------------------------
// Each request on the req_ stream carries a target point, a reference point and
// the reference orientation in milliradians. Each request yields exactly one
// response on the rsp_ stream, in order: the absolute heading (0..two pi - 1),
// a flag that is low when the two points coincide, and the heading unwrapped
// toward the orientation minus that orientation.
// The block is a fixed pipeline of 31 register stages: one delta stage, three
// normalizer stages, one stage per cordic iteration (24) and three stages of
// quadrant fold, wrap and unwrap. Unless the receiver stalls the pipeline, a new
// request is taken every cycle; throughput is one item per cycle.
// When the receiver holds rsp_tready low with a response pending, the whole
// pipeline freezes and req_tready drops; nothing is lost or repeated.
// Reset clears all stage valid bits; the pipeline is then empty and ready.
// ----------------------------------------------------------------------------
module relative_heading_unit #(
   parameter int TWO_PI_MRAD = 6283,
   parameter int COORD_BITS  = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // target_x, target_y, ref_x, ref_y (COORD_BITS each), ref_orientation (14)
   input  logic [((4*COORD_BITS+14+7)/8)*8-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // abs_heading (13), relative_heading (15), zero pad (4)
   output logic [31:0] rsp_tdata,
   // heading_valid (1)
   output logic        rsp_tuser
);

   localparam int CB    = COORD_BITS;
   localparam int MAG_W = COORD_BITS + 1;

   logic                   advance;
   logic signed [CB:0]     dx, dy;
   logic [MAG_W-1:0]       mx_in, my_in, mx_ff, my_ff;
   rhu_pkg::side_type      s0_in, s0_ff;
   rhu_pkg::pair_type      norm_pair;
   rhu_pkg::side_type      norm_side;
   logic signed [rhu_pkg::ZW-1:0] z_angle;
   rhu_pkg::side_type      z_side;
   logic [12:0]            abs_heading;
   logic                   heading_valid;
   logic [14:0]            relative_heading;

   // stall everything only when a response waits and is refused
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // deltas and magnitudes
   always_comb begin
      dx = $signed({req_tdata[CB-1], req_tdata[CB-1:0]})
         - $signed({req_tdata[3*CB-1], req_tdata[3*CB-1:2*CB]});
      dy = $signed({req_tdata[2*CB-1], req_tdata[2*CB-1:CB]})
         - $signed({req_tdata[4*CB-1], req_tdata[4*CB-1:3*CB]});
      mx_in = dx[CB] ? MAG_W'(-dx) : MAG_W'(dx);
      my_in = dy[CB] ? MAG_W'(-dy) : MAG_W'(dy);
      s0_in.valid  = req_tvalid;
      s0_in.zero   = (dx == '0) && (dy == '0);
      s0_in.dx_neg = dx[CB];
      s0_in.dy_neg = dy[CB];
      s0_in.orient = req_tdata[4*CB+13:4*CB];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         s0_ff <= s0_in;
      end
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end
   end

   rhu_norm #(.MAG_W(MAG_W)) u_norm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .mag_x     (mx_ff),
      .mag_y     (my_ff),
      .side_src  (s0_ff),
      .norm_pair (norm_pair),
      .norm_side (norm_side)
   );

   rhu_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .norm_pair (norm_pair),
      .norm_side (norm_side),
      .z_angle   (z_angle),
      .z_side    (z_side)
   );

   rhu_post #(.TWO_PI(TWO_PI_MRAD)) u_post (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .z_angle          (z_angle),
      .z_side           (z_side),
      .out_valid        (rsp_tvalid),
      .abs_heading      (abs_heading),
      .heading_valid    (heading_valid),
      .relative_heading (relative_heading)
   );

   assign rsp_tdata = {4'b0, relative_heading, abs_heading};
   assign rsp_tuser = heading_valid;

endmodule
